// ----- hw/rtl/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Types, widths and register codes shared by the ray/triangle intersect block.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int SLOT_W     = 21;
  localparam int NORM_W     = 21;
  localparam int CFG_W      = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int MARGIN_W   = 16;
  localparam int T_W        = 32;
  localparam int FRAC_T     = 16;
  localparam int CROSS_DROP = 11;
  localparam int DIFF_W     = SLOT_W + 1;
  localparam int NUM_W      = 45;
  localparam int DEN_W      = 44;
  localparam int QUO_W      = 33;
  localparam int REM_W      = DEN_W + 1;
  localparam int DEF_COORD_BITS = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A    = 3'd0,
    REG_VERTEX_B    = 3'd1,
    REG_VERTEX_C    = 3'd2,
    REG_NORMAL      = 3'd3,
    REG_EDGE_MARGIN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][2:0][SLOT_W-1:0] v;
    logic [2:0][NORM_W-1:0]      n;
    logic [MARGIN_W-1:0]         margin;
  } tri_cfg_t;

  typedef struct packed {
    logic [2:0][SLOT_W-1:0] s;
    logic [2:0][SLOT_W-1:0] d;
  } ray_t;

  typedef struct packed {
    logic             parallel;
    logic             neg;
    logic             ovf;
    logic [NUM_W-1:0] mag_n;
    logic [DEN_W-1:0] mag_d;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    ray_t             ray;
  } div_t;

  typedef struct packed {
    logic                   parallel;
    logic [T_W-1:0]         t;
    logic [2:0][SLOT_W-1:0] p;
  } point_t;

  typedef struct packed {
    logic                   hit;
    logic                   parallel;
    logic [T_W-1:0]         t;
    logic [2:0][SLOT_W-1:0] p;
  } result_t;

endpackage

// ----- hw/rtl/rti_plane.sv -----
// ----------------------------------------------------------------------------
// rti_plane
// Forms n.d and -n.(s-a) over three stages, then sets up the divider.
// ----------------------------------------------------------------------------
module rti_plane (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  rti_pkg::ray_t    in_ray,
  input  rti_pkg::tri_cfg_t cfg,
  output logic             out_valid,
  output rti_pkg::div_t    out_div
);
  import rti_pkg::*;

  localparam int PN_W = NORM_W + DIFF_W;
  localparam int PD_W = NORM_W + SLOT_W;

  logic                          v1, v2, v3;
  ray_t                          ray1, ray2, ray3;
  logic signed [2:0][DIFF_W-1:0] diff1;
  logic signed [2:0][PN_W-1:0]   pn2;
  logic signed [2:0][PD_W-1:0]   pd2;
  logic signed [NUM_W-1:0]       num3;
  logic signed [DEN_W-1:0]       den3;
  div_t                          prep;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1 <= in_ray;
      ray2 <= ray1;
      ray3 <= ray2;
      for (int i = 0; i < 3; i++) begin
        diff1[i] <= DIFF_W'(signed'(in_ray.s[i])) - DIFF_W'(signed'(cfg.v[0][i]));
        pn2[i] <= PN_W'(signed'(diff1[i])) * PN_W'(signed'(cfg.n[i]));
        pd2[i] <= PD_W'(signed'(ray1.d[i])) * PD_W'(signed'(cfg.n[i]));
      end
      num3 <= -(NUM_W'(signed'(pn2[0])) + NUM_W'(signed'(pn2[1]))
              + NUM_W'(signed'(pn2[2])));
      den3 <= DEN_W'(signed'(pd2[0])) + DEN_W'(signed'(pd2[1]))
              + DEN_W'(signed'(pd2[2]));
      out_div <= prep;
    end
  end

  always_comb begin
    prep.parallel = (den3 == '0);
    prep.neg      = num3[NUM_W-1] ^ den3[DEN_W-1];
    prep.mag_n    = num3[NUM_W-1] ? NUM_W'(-num3) : NUM_W'(num3);
    prep.mag_d    = den3[DEN_W-1] ? DEN_W'(-den3) : DEN_W'(den3);
    prep.ovf      = REM_W'(prep.mag_n[NUM_W-1:QUO_W-FRAC_T]) >= REM_W'(prep.mag_d);
    prep.rem      = REM_W'(prep.mag_n[NUM_W-1:QUO_W-FRAC_T]);
    prep.quo      = '0;
    prep.ray      = ray3;
  end

endmodule

// ----- hw/rtl/rti_divider.sv -----
// ----------------------------------------------------------------------------
// rti_divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rti_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  rti_pkg::div_t in_div,
  output logic          out_valid,
  output rti_pkg::div_t out_div
);
  import rti_pkg::*;

  logic [QUO_W:0] vld;
  div_t           stg [QUO_W+1];

  assign vld[0] = in_valid;
  assign stg[0] = in_div;

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int K = QUO_W - 1 - j;
    logic             nbit;
    logic [REM_W-1:0] shifted;
    div_t             nxt;

    if (K >= FRAC_T) begin : g_bit
      assign nbit = stg[j].mag_n[K-FRAC_T];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    always_comb begin
      shifted = {stg[j].rem[REM_W-2:0], nbit};
      nxt = stg[j];
      if (shifted >= REM_W'(stg[j].mag_d)) begin
        nxt.rem = shifted - REM_W'(stg[j].mag_d);
        nxt.quo[K] = 1'b1;
      end else begin
        nxt.rem = shifted;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[j+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign out_div   = stg[QUO_W];

endmodule

// ----- hw/rtl/rti_point.sv -----
// ----------------------------------------------------------------------------
// rti_point
// Signs and saturates t, then forms the saturated point s + t*d.
// ----------------------------------------------------------------------------
module rti_point #(
  parameter int COORD_BITS = rti_pkg::DEF_COORD_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rti_pkg::div_t   in_div,
  output logic            out_valid,
  output rti_pkg::point_t out_pt
);
  import rti_pkg::*;

  localparam int PROD_W = T_W + SLOT_W;
  localparam int SUM_W  = PROD_W - FRAC_T + 1;
  localparam logic signed [SUM_W-1:0] CMAX =
    SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);
  localparam logic [QUO_W-1:0] QMAX_POS = QUO_W'((64'd1 << (T_W - 1)) - 64'd1);
  localparam logic [QUO_W-1:0] QMAX_NEG = QUO_W'(64'd1 << (T_W - 1));

  logic                          va, vb;
  logic                          par_a, par_b;
  ray_t                          ray_a, ray_b;
  logic signed [T_W-1:0]         t_next, t_a, t_b;
  logic signed [2:0][PROD_W-1:0] prod_b;
  point_t                        pt_next;
  logic signed [SUM_W-1:0]       sum;

  always_comb begin
    if (in_div.neg) begin
      t_next = (in_div.ovf || in_div.quo > QMAX_NEG) ? {1'b1, {(T_W-1){1'b0}}}
                                                      : T_W'(-in_div.quo);
    end else begin
      t_next = (in_div.ovf || in_div.quo > QMAX_POS) ? {1'b0, {(T_W-1){1'b1}}}
                                                      : T_W'(in_div.quo);
    end
  end

  always_comb begin
    pt_next.parallel = par_b;
    pt_next.t        = t_b;
    sum              = '0;
    for (int i = 0; i < 3; i++) begin
      sum = SUM_W'(signed'(prod_b[i]) >>> FRAC_T) + SUM_W'(signed'(ray_b.s[i]));
      if (sum > CMAX) begin
        pt_next.p[i] = SLOT_W'(CMAX);
      end else if (sum < CMIN) begin
        pt_next.p[i] = SLOT_W'(CMIN);
      end else begin
        pt_next.p[i] = SLOT_W'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a   <= t_next;
      par_a <= in_div.parallel;
      ray_a <= in_div.ray;
      t_b   <= t_a;
      par_b <= par_a;
      ray_b <= ray_a;
      for (int i = 0; i < 3; i++) begin
        prod_b[i] <= PROD_W'(t_a) * PROD_W'(signed'(ray_a.d[i]));
      end
      out_pt <= pt_next;
    end
  end

endmodule

// ----- hw/rtl/rti_edge.sv -----
// ----------------------------------------------------------------------------
// rti_edge
// Edge test: three cross products dotted with the normal, against the margin.
// ----------------------------------------------------------------------------
module rti_edge (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  rti_pkg::point_t   in_pt,
  input  rti_pkg::tri_cfg_t cfg,
  output logic              out_valid,
  output rti_pkg::result_t  out_res
);
  import rti_pkg::*;

  localparam int XP_W  = 2 * DIFF_W;
  localparam int CR_W  = XP_W + 1;
  localparam int CF_W  = CR_W - CROSS_DROP;
  localparam int CN_W  = CF_W + NORM_W;
  localparam int ES_W  = CN_W + 2;

  logic                               v1, v2, v3, v4;
  point_t                             pt1, pt2, pt3, pt4;
  logic signed [2:0][2:0][DIFF_W-1:0] e1, w1;
  logic signed [2:0][2:0][XP_W-1:0]   pa2, pb2;
  logic signed [2:0][2:0][CF_W-1:0]   cf3;
  logic signed [2:0][2:0][CN_W-1:0]   cn4;
  logic [2:0]                         pass;
  result_t                            res_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pass[k] = (ES_W'(signed'(cn4[k][0])) + ES_W'(signed'(cn4[k][1]))
                 + ES_W'(signed'(cn4[k][2])))
                >= signed'(ES_W'(cfg.margin));
    end
    res_next.parallel = pt4.parallel;
    res_next.hit      = !pt4.parallel && (&pass);
    res_next.t        = pt4.parallel ? '0 : pt4.t;
    res_next.p        = pt4.parallel ? '0 : pt4.p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1 <= in_pt;
      pt2 <= pt1;
      pt3 <= pt2;
      pt4 <= pt3;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          e1[k][i] <= DIFF_W'(signed'(cfg.v[(k+1)%3][i])) - DIFF_W'(signed'(cfg.v[k][i]));
          w1[k][i] <= DIFF_W'(signed'(in_pt.p[i])) - DIFF_W'(signed'(cfg.v[k][i]));
          pa2[k][i] <= XP_W'(signed'(e1[k][(i+1)%3])) * XP_W'(signed'(w1[k][(i+2)%3]));
          pb2[k][i] <= XP_W'(signed'(e1[k][(i+2)%3])) * XP_W'(signed'(w1[k][(i+1)%3]));
          cf3[k][i] <= CF_W'((CR_W'(signed'(pa2[k][i])) - CR_W'(signed'(pb2[k][i])))
                             >>> CROSS_DROP);
          cn4[k][i] <= CN_W'(signed'(cf3[k][i])) * CN_W'(signed'(cfg.n[i]));
        end
      end
      out_res <= res_next;
    end
  end

endmodule

// ----- hw/rtl/ray_triangle_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Intersects a stream of rays with one triangle held in configuration.
//
//   Channel   Direction  Handshake           Contents
//   s_axis    in         s_tvalid/s_tready   ray start and direction
//   m_axis    out        m_tvalid/m_tready   hit, parallel, t, point
//   cfg       in         cfg_we              vertices, normal, edge margin
//
// One word enters per cycle while the output register is empty or taken; the
// 33-stage restoring divider sits between the plane and point stages.
// Reset clears the valid bits of every stage and loads the register defaults.
// All stages advance together whenever the output register is empty or taken.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_BITS = rti_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z, 2 pad bits
  input  logic [127:0]                  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // hit, parallel, ray_param, point_x, point_y, point_z, 7 pad bits
  output logic [103:0]                  m_tdata,
  input  logic                          cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::CFG_W-1:0]     cfg_data
);
  import rti_pkg::*;

  logic [2:0][CFG_W-1:0] vertex;
  logic [CFG_W-1:0]      normal;
  logic [MARGIN_W-1:0]   margin;
  tri_cfg_t              cfg;
  ray_t                  ray;
  logic                  en;
  logic                  pl_valid, dv_valid, pt_valid;
  div_t                  pl_div, dv_div;
  point_t                pt;
  result_t               res;

  function automatic logic [SLOT_W-1:0] sext_coord(input logic [SLOT_W-1:0] x);
    logic signed [COORD_BITS-1:0] c;
    c = x[COORD_BITS-1:0];
    return SLOT_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex <= '0;
      normal <= '0;
      margin <= MARGIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_A:    vertex[0] <= cfg_data;
        REG_VERTEX_B:    vertex[1] <= cfg_data;
        REG_VERTEX_C:    vertex[2] <= cfg_data;
        REG_NORMAL:      normal    <= cfg_data;
        REG_EDGE_MARGIN: margin    <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        cfg.v[k][i] = sext_coord(vertex[k][i*SLOT_W +: SLOT_W]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      cfg.n[i]   = normal[i*NORM_W +: NORM_W];
      ray.s[i]   = sext_coord(s_tdata[i*SLOT_W +: SLOT_W]);
      ray.d[i]   = sext_coord(s_tdata[(i+3)*SLOT_W +: SLOT_W]);
    end
    cfg.margin = margin;
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rti_plane u_plane (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready), .in_ray(ray), .cfg(cfg),
    .out_valid(pl_valid), .out_div(pl_div)
  );

  rti_divider u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pl_valid), .in_div(pl_div),
    .out_valid(dv_valid), .out_div(dv_div)
  );

  rti_point #(.COORD_BITS(COORD_BITS)) u_point (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dv_valid), .in_div(dv_div),
    .out_valid(pt_valid), .out_pt(pt)
  );

  rti_edge u_edge (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(pt_valid), .in_pt(pt), .cfg(cfg),
    .out_valid(m_tvalid), .out_res(res)
  );

  assign m_tdata = {7'd0, res.p[2], res.p[1], res.p[0], res.t, res.parallel, res.hit};

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.parallel |-> !res.hit && res.t == '0 && res.p == '0)
    else $error("parallel result carries nonzero fields");

  a_point_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.p[0][SLOT_W-1:COORD_BITS-1] == '0 ||
                  res.p[0][SLOT_W-1:COORD_BITS-1] == '1))
    else $error("point_x outside coordinate range");

  a_point_z_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.p[2][SLOT_W-1:COORD_BITS-1] == '0 ||
                  res.p[2][SLOT_W-1:COORD_BITS-1] == '1))
    else $error("point_z outside coordinate range");

endmodule
